>>> rtl/core/mant_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active note tracker package
// Shared sizes, MIDI codes, the command passed from front end to back end and
// the note store address function.
// ----------------------------------------------------------------------------
package mant_pkg;

	localparam int CHANNELS   = 16;
	localparam int NOTES      = 128;
	localparam int COUNT_BITS = 8;

	localparam int DEPTH       = CHANNELS * NOTES;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int COUNT_MAX_I = (1 << COUNT_BITS) - 1;
	localparam int CHCNT_MAX_I = NOTES * COUNT_MAX_I;
	localparam int CHCNT_W     = $clog2(CHCNT_MAX_I + 1);
	localparam int TOTAL_W     = $clog2(CHANNELS * CHCNT_MAX_I + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [CHCNT_W-1:0]    CHCNT_MAX = CHCNT_W'(CHCNT_MAX_I);

	localparam int NOTE_OUT_W  = 8;
	localparam int CHAN_OUT_W  = 15;
	localparam int TOTAL_OUT_W = 19;

	localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
	localparam logic [3:0] TYPE_CTRL     = 4'hB;
	localparam logic [3:0] TYPE_LAST    = 4'hE;
	localparam logic [6:0] CTRL_DAMPER   = 7'd64;
	localparam logic [6:0] CTRL_ALL_OFF  = 7'd123;
	localparam int         PEDAL_BIT     = 6;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_UP,
		OP_DOWN,
		OP_PEDAL,
		OP_WIPE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] ch;
		logic [6:0] note;
		logic       ch_ok;
		logic       note_ok;
		logic       pedal_val;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] ch, input logic [6:0] note);
		addr_of = ADDR_W'(32'(ch) * NOTES + 32'(note));
	endfunction

endpackage

>>> rtl/core/mant_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message request channel
// Valid/ready channel carrying one MIDI message or a clear request.
// ----------------------------------------------------------------------------
interface mant_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] status_byte;
	logic [6:0] data_one;
	logic [6:0] data_two;

	modport source(output valid, output kind, output status_byte, output data_one,
		output data_two, input ready);
	modport sink(input valid, input kind, input status_byte, input data_one,
		input data_two, output ready);
endinterface

>>> rtl/core/mant_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker response channel
// Valid/ready channel carrying the handled flag and the counts after update.
// ----------------------------------------------------------------------------
interface mant_rsp_if;
	logic        valid;
	logic        ready;
	logic        handled;
	logic [7:0]  note_count;
	logic [14:0] channel_count;
	logic [18:0] total_count;
	logic        hold_pedal;

	modport source(output valid, output handled, output note_count, output channel_count,
		output total_count, output hold_pedal, input ready);
	modport sink(input valid, input handled, input note_count, input channel_count,
		input total_count, input hold_pedal, output ready);
endinterface

>>> rtl/core/mant_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mant_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/mant_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker front end
// Decodes each request into a tracker command and queues it for the back end.
// ----------------------------------------------------------------------------
module mant_front (
	input  logic            clk,
	input  logic            arst_n,
	mant_req_if.sink        req,
	output mant_pkg::cmd_t  cmd,
	output logic            cmd_valid,
	input  logic            cmd_ready
);

	localparam int QDEPTH = 2;

	mant_pkg::cmd_t dec;
	mant_pkg::cmd_t queue_q [QDEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic [3:0]     msg_type;
	logic           push;
	logic           pop;

	always_comb begin
		msg_type      = req.status_byte[7:4];
		dec.ch        = req.status_byte[3:0];
		dec.note      = req.data_one;
		dec.ch_ok     = 32'(req.status_byte[3:0]) < mant_pkg::CHANNELS;
		dec.note_ok   = 32'(req.data_one) < mant_pkg::NOTES;
		dec.pedal_val = req.data_two[mant_pkg::PEDAL_BIT];
		dec.op        = mant_pkg::OP_NONE;
		if (req.kind) begin
			dec.op = mant_pkg::OP_CLEAR;
		end else if (msg_type[3] && msg_type <= mant_pkg::TYPE_LAST && dec.ch_ok) begin
			if (msg_type == mant_pkg::TYPE_CTRL && req.data_one == mant_pkg::CTRL_ALL_OFF) begin
				dec.op = mant_pkg::OP_WIPE;
			end else if (msg_type == mant_pkg::TYPE_NOTE_ON && dec.note_ok) begin
				dec.op = (req.data_two != 7'd0) ? mant_pkg::OP_UP : mant_pkg::OP_DOWN;
			end else if (msg_type == mant_pkg::TYPE_NOTE_OFF && dec.note_ok) begin
				dec.op = mant_pkg::OP_DOWN;
			end else if (msg_type == mant_pkg::TYPE_CTRL && req.data_one == mant_pkg::CTRL_DAMPER) begin
				dec.op = mant_pkg::OP_PEDAL;
			end
		end
	end

	assign req.ready = fill_q != 2'(QDEPTH);
	assign push      = req.valid && req.ready;
	assign cmd_valid = fill_q != 2'd0;
	assign cmd       = queue_q[rd_ptr_q];
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/mant_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker back end
// Executes queued commands against the note store, the channel and total
// counts and the pedal flags, and holds each response until it is taken.
// ----------------------------------------------------------------------------
module mant_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mant_pkg::cmd_t  cmd,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	mant_rsp_if.source      rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_WIPE = 2'd2;

	logic [1:0]                         state_q;
	mant_pkg::cmd_t                     cur_q;
	logic [mant_pkg::ADDR_W-1:0]        wipe_addr_q;
	logic [mant_pkg::ADDR_W-1:0]        wipe_last_q;
	logic                               wipe_report_q;
	logic                               wipe_handled_q;
	logic [mant_pkg::CHCNT_W-1:0]       chcnt_q [mant_pkg::CHANNELS];
	logic                               pedal_q [mant_pkg::CHANNELS];
	logic [mant_pkg::TOTAL_W-1:0]       tot_q;

	logic                               rsp_valid_q;
	logic                               rsp_handled_q;
	logic [mant_pkg::NOTE_OUT_W-1:0]    rsp_note_q;
	logic [mant_pkg::CHAN_OUT_W-1:0]    rsp_chan_q;
	logic [mant_pkg::TOTAL_OUT_W-1:0]   rsp_total_q;
	logic                               rsp_pedal_q;

	logic                               pop;
	logic [mant_pkg::CH_W-1:0]          pop_idx;
	logic [mant_pkg::CH_W-1:0]          cur_idx;
	logic [mant_pkg::ADDR_W-1:0]        ram_waddr;
	logic [mant_pkg::COUNT_BITS-1:0]    ram_wdata;
	logic                               ram_we;
	logic [mant_pkg::COUNT_BITS-1:0]    ram_rdata;
	logic [mant_pkg::COUNT_BITS-1:0]    cnt_new;
	logic [mant_pkg::CHCNT_W-1:0]       chcnt_new;
	logic [mant_pkg::TOTAL_W-1:0]       tot_new;
	logic                               ped_new;
	logic                               wipe_done;

	mant_ram #(
		.WIDTH(mant_pkg::COUNT_BITS),
		.DEPTH(mant_pkg::DEPTH)
	) u_note_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(mant_pkg::addr_of(cmd.ch, cmd.note)),
		.rdata(ram_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign pop       = cmd_valid && cmd_ready;
	assign pop_idx   = cmd.ch[mant_pkg::CH_W-1:0];
	assign cur_idx   = cur_q.ch[mant_pkg::CH_W-1:0];
	assign wipe_done = wipe_addr_q == wipe_last_q;

	always_comb begin
		cnt_new   = ram_rdata;
		chcnt_new = chcnt_q[cur_idx];
		tot_new   = tot_q;
		ped_new   = pedal_q[cur_idx];
		case (cur_q.op)
			mant_pkg::OP_UP: begin
				if (ram_rdata != mant_pkg::COUNT_MAX) begin
					cnt_new   = ram_rdata + mant_pkg::COUNT_BITS'(1);
					chcnt_new = chcnt_q[cur_idx] + mant_pkg::CHCNT_W'(1);
					tot_new   = tot_q + mant_pkg::TOTAL_W'(1);
				end
			end
			mant_pkg::OP_DOWN: begin
				if (ram_rdata != '0) begin
					cnt_new   = ram_rdata - mant_pkg::COUNT_BITS'(1);
					chcnt_new = chcnt_q[cur_idx] - mant_pkg::CHCNT_W'(1);
					tot_new   = tot_q - mant_pkg::TOTAL_W'(1);
				end
			end
			mant_pkg::OP_PEDAL: ped_new = cur_q.pedal_val;
			default: ;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wipe_addr_q;
		ram_wdata = '0;
		if (state_q == ST_WIPE) begin
			ram_we = 1'b1;
		end else if (state_q == ST_MOD) begin
			ram_we    = cur_q.op inside {mant_pkg::OP_UP, mant_pkg::OP_DOWN};
			ram_waddr = mant_pkg::addr_of(cur_q.ch, cur_q.note);
			ram_wdata = cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
		if (state_q == ST_MOD) begin
			rsp_handled_q <= cur_q.op inside {mant_pkg::OP_UP, mant_pkg::OP_DOWN};
			rsp_note_q    <= (cur_q.ch_ok && cur_q.note_ok) ?
				mant_pkg::NOTE_OUT_W'(cnt_new) : '0;
			rsp_chan_q    <= cur_q.ch_ok ? mant_pkg::CHAN_OUT_W'(chcnt_new) : '0;
			rsp_total_q   <= mant_pkg::TOTAL_OUT_W'(tot_new);
			rsp_pedal_q   <= cur_q.ch_ok && ped_new;
		end else if (state_q == ST_WIPE && wipe_done) begin
			rsp_handled_q <= wipe_handled_q;
			rsp_note_q    <= '0;
			rsp_chan_q    <= '0;
			rsp_total_q   <= mant_pkg::TOTAL_OUT_W'(tot_q);
			rsp_pedal_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_WIPE;
			wipe_addr_q    <= '0;
			wipe_last_q    <= mant_pkg::ADDR_W'(mant_pkg::DEPTH - 1);
			wipe_report_q  <= 1'b0;
			wipe_handled_q <= 1'b0;
			tot_q          <= '0;
			rsp_valid_q    <= 1'b0;
			for (int c = 0; c < mant_pkg::CHANNELS; c++) begin
				chcnt_q[c] <= '0;
				pedal_q[c] <= 1'b0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (cmd.op)
							mant_pkg::OP_CLEAR: begin
								state_q        <= ST_WIPE;
								wipe_addr_q    <= '0;
								wipe_last_q    <= mant_pkg::ADDR_W'(mant_pkg::DEPTH - 1);
								wipe_report_q  <= 1'b1;
								wipe_handled_q <= 1'b0;
								tot_q          <= '0;
								for (int c = 0; c < mant_pkg::CHANNELS; c++) begin
									chcnt_q[c] <= '0;
									pedal_q[c] <= 1'b0;
								end
							end
							mant_pkg::OP_WIPE: begin
								state_q          <= ST_WIPE;
								wipe_addr_q      <= mant_pkg::addr_of(cmd.ch, 7'd0);
								wipe_last_q      <= mant_pkg::ADDR_W'(32'(cmd.ch) * mant_pkg::NOTES
									+ mant_pkg::NOTES - 1);
								wipe_report_q    <= 1'b1;
								wipe_handled_q   <= 1'b1;
								tot_q            <= tot_q - mant_pkg::TOTAL_W'(chcnt_q[pop_idx]);
								chcnt_q[pop_idx] <= '0;
								pedal_q[pop_idx] <= 1'b0;
							end
							default: state_q <= ST_MOD;
						endcase
					end
				end
				ST_MOD: begin
					if (cur_q.ch_ok) begin
						chcnt_q[cur_idx] <= chcnt_new;
						pedal_q[cur_idx] <= ped_new;
					end
					tot_q       <= tot_new;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_WIPE: begin
					if (wipe_done) begin
						rsp_valid_q <= wipe_report_q;
						state_q     <= ST_IDLE;
					end else begin
						wipe_addr_q <= wipe_addr_q + mant_pkg::ADDR_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.handled       = rsp_handled_q;
	assign rsp.note_count    = rsp_note_q;
	assign rsp.channel_count = rsp_chan_q;
	assign rsp.total_count   = rsp_total_q;
	assign rsp.hold_pedal    = rsp_pedal_q;

	a_mod_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> $past(state_q) == ST_IDLE)
		else $error("read-modify-write step not entered from idle");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> !rsp_valid_q)
		else $error("response register occupied when a result is due");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we)
		else $error("note store written while idle");

	a_wipe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WIPE |-> wipe_addr_q <= wipe_last_q)
		else $error("wipe address passed its last entry");

	a_chcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD && cur_q.ch_ok |-> chcnt_q[cur_idx] <= mant_pkg::CHCNT_MAX)
		else $error("channel count above its bound");

endmodule

>>> rtl/core/midi_active_note_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI active note tracker
// Counts sounding notes per channel and note, per channel and in total, and
// keeps a damper pedal flag per channel.
// ----------------------------------------------------------------------------
// Each request transfer gives exactly one response transfer. A note or
// controller message first reads the note store in the back end, then
// writes it back and registers the response. All-notes-off walks the
// channel's 128 store entries, a clear request walks all 2048 entries.
// After reset the back end first zeroes all 2048 note store entries; the
// two-entry request queue still takes transfers during that sweep and
// during any walk, and a pending response does not stop the queue from
// filling.
module midi_active_note_tracker (
	input  logic        clk,
	input  logic        arst_n,
	mant_req_if.sink    req,
	mant_rsp_if.source  rsp
);

	mant_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_ready;

	mant_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready)
	);

	mant_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.rsp      (rsp)
	);

endmodule
